// ===== rtl/lcal_pkg.sv =====
`default_nettype none

package lcal_pkg;

   // tree size and lifting depth
   localparam int MAX_NODES  = 1024;
   localparam int LOG_LEVELS = 10;

   localparam int NODE_W  = 10;
   localparam int DEPTH_W = 10;
   localparam int LEVEL_W = $clog2(LOG_LEVELS);

   // ancestor store: one row of MAX_NODES entries per lifting level
   localparam int ANC_DEPTH = LOG_LEVELS * MAX_NODES;
   localparam int ANC_AW    = LEVEL_W + NODE_W;

   localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

   typedef logic [NODE_W-1:0]  node_type;
   typedef logic [DEPTH_W-1:0] depth_type;
   typedef logic [LEVEL_W-1:0] level_type;
   typedef logic [ANC_AW-1:0]  anc_addr_type;

   // request operation codes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

endpackage : lcal_pkg

`default_nettype wire

// ===== rtl/lowest_common_ancestor_lifting.sv =====
// Lowest common ancestor by binary lifting over a stored rooted tree.
// Request channel (req_valid / req_stall): req_operation selects a load or
// a query. A load writes node req_first_node with parent req_second_node
// (parent 0 marks a root) and gives no response; loads must come
// parents-first. A query asks for the common ancestor of the two nodes and
// gives one response on rsp_valid / rsp_stall with rsp_common_ancestor.
// One request is worked on at a time; req_stall is high while busy.
// A load writes level 0 from the parent, then reads and writes one
// ancestor-table entry per level. A query orders the two nodes by depth,
// lifts the deeper node level by level, and, if the lifted node is not the
// answer, lifts both from the top level down before a final level-0 read.
// The ancestor table is a single memory with one write and two registered
// read ports.
// Reset clears the sequencer and the response register only; the depth and
// ancestor stores hold garbage until loaded, and node 0 always reads as the
// null ancestor. A finished response waits in its register while rsp_stall
// is high; a new request is taken meanwhile, but its own response waits.

`default_nettype none

module lowest_common_ancestor_lifting (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_operation,
   input  wire lcal_pkg::node_type req_first_node,
   input  wire lcal_pkg::node_type req_second_node,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output lcal_pkg::node_type      rsp_common_ancestor
);

   import lcal_pkg::*;

   typedef enum logic [3:0] {
      IDLE,
      LD_DEP,
      LD_RD,
      LD_WR,
      Q_DEP,
      Q_LIFT,
      Q_LIFT_WR,
      Q_CMP,
      Q_DESC,
      Q_DESC_CMP,
      Q_FIN,
      Q_FIN_WR,
      PUT
   } state_type;

   localparam level_type LEVEL_TOP = level_type'(LOG_LEVELS - 1);

   state_type state_ff, state_in;
   level_type level_ff, level_in;
   node_type  a_ff, a_in;
   node_type  b_ff, b_in;
   node_type  mid_ff, mid_in;
   node_type  result_ff, result_in;
   depth_type diff_ff, diff_in;
   logic      rsp_valid_ff, rsp_valid_in;
   node_type  rsp_data_ff, rsp_data_in;

   // memories
   depth_type depth_mem [MAX_NODES];
   node_type  anc_mem [ANC_DEPTH];

   node_type     dep_ra_addr, dep_rb_addr;
   depth_type    dep_ra_ff, dep_rb_ff;
   logic         dep_za_ff, dep_zb_ff;
   logic         dep_we;
   depth_type    dep_wdata;

   anc_addr_type anc_ra_addr, anc_rb_addr, anc_waddr;
   node_type     anc_ra_node, anc_rb_node;
   node_type     anc_ra_ff, anc_rb_ff;
   logic         anc_za_ff, anc_zb_ff;
   logic         anc_we;
   node_type     anc_wdata;

   depth_type depth_a, depth_b;
   node_type  anc_a, anc_b;
   logic [DEPTH_W:0] depth_inc;
   logic      req_accept;
   logic      rsp_free;

   // node 0 is the null ancestor: reads of it give zero
   assign depth_a = dep_za_ff ? '0 : dep_ra_ff;
   assign depth_b = dep_zb_ff ? '0 : dep_rb_ff;
   assign anc_a   = anc_za_ff ? '0 : anc_ra_ff;
   assign anc_b   = anc_zb_ff ? '0 : anc_rb_ff;

   assign anc_ra_node = anc_ra_addr[NODE_W-1:0];
   assign anc_rb_node = anc_rb_addr[NODE_W-1:0];

   assign req_stall  = (state_ff != IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign depth_inc  = {1'b0, depth_b} + 1'b1;

   // depth store, two registered read ports
   always_ff @(posedge clock) begin
      if (dep_we) begin
         depth_mem[a_ff] <= dep_wdata;
      end
      dep_ra_ff <= depth_mem[dep_ra_addr];
      dep_rb_ff <= depth_mem[dep_rb_addr];
      dep_za_ff <= (dep_ra_addr == '0);
      dep_zb_ff <= (dep_rb_addr == '0);
   end

   // ancestor store, two registered read ports
   always_ff @(posedge clock) begin
      if (anc_we) begin
         anc_mem[anc_waddr] <= anc_wdata;
      end
      anc_ra_ff <= anc_mem[anc_ra_addr];
      anc_rb_ff <= anc_mem[anc_rb_addr];
      anc_za_ff <= (anc_ra_node == '0);
      anc_zb_ff <= (anc_rb_node == '0);
   end

   // read address selection
   always_comb begin
      dep_ra_addr = req_first_node;
      dep_rb_addr = req_second_node;
      anc_ra_addr = {level_ff, a_ff};
      anc_rb_addr = {level_ff, b_ff};
      unique case (state_ff)
         LD_RD:   anc_ra_addr = {level_type'(level_ff - 1'b1), mid_ff};
         Q_FIN:   anc_ra_addr = {level_type'(0), a_ff};
         default: ;
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      level_in     = level_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      mid_in       = mid_ff;
      result_in    = result_ff;
      diff_in      = diff_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      dep_we       = 1'b0;
      dep_wdata    = '0;
      anc_we       = 1'b0;
      anc_waddr    = {level_ff, a_ff};
      anc_wdata    = anc_a;
      unique case (state_ff)
         IDLE: begin
            if (req_accept) begin
               a_in = req_first_node;
               b_in = req_second_node;
               if (req_operation == OP_QUERY) begin
                  state_in = Q_DEP;
               end else if (req_first_node != '0) begin
                  state_in = LD_DEP;
               end
            end
         end
         // load: depth and level 0 from the parent
         LD_DEP: begin
            dep_we = 1'b1;
            if (b_ff == '0) begin
               dep_wdata = '0;
            end else if (depth_inc[DEPTH_W]) begin
               dep_wdata = DEPTH_MAX;
            end else begin
               dep_wdata = depth_inc[DEPTH_W-1:0];
            end
            anc_we    = 1'b1;
            anc_waddr = {level_type'(0), a_ff};
            anc_wdata = b_ff;
            mid_in    = b_ff;
            level_in  = level_type'(1);
            state_in  = LD_RD;
         end
         LD_RD: begin
            state_in = LD_WR;
         end
         // load: level k from level k-1 of the midpoint
         LD_WR: begin
            anc_we    = 1'b1;
            anc_waddr = {level_ff, a_ff};
            anc_wdata = anc_a;
            mid_in    = anc_a;
            if (level_ff == LEVEL_TOP) begin
               state_in = IDLE;
            end else begin
               level_in = level_ff + 1'b1;
               state_in = LD_RD;
            end
         end
         // query: order by depth
         Q_DEP: begin
            if (depth_a < depth_b) begin
               a_in    = b_ff;
               b_in    = a_ff;
               diff_in = depth_b - depth_a;
            end else begin
               diff_in = depth_a - depth_b;
            end
            level_in = '0;
            state_in = Q_LIFT;
         end
         // lift the deeper node by the depth difference
         Q_LIFT: begin
            if (diff_ff[level_ff]) begin
               state_in = Q_LIFT_WR;
            end else if (level_ff == LEVEL_TOP) begin
               state_in = Q_CMP;
            end else begin
               level_in = level_ff + 1'b1;
            end
         end
         Q_LIFT_WR: begin
            a_in = anc_a;
            if (level_ff == LEVEL_TOP) begin
               state_in = Q_CMP;
            end else begin
               level_in = level_ff + 1'b1;
               state_in = Q_LIFT;
            end
         end
         Q_CMP: begin
            if (a_ff == b_ff) begin
               result_in = a_ff;
               state_in  = PUT;
            end else begin
               level_in = LEVEL_TOP;
               state_in = Q_DESC;
            end
         end
         // lift both from the top level down while ancestors differ
         Q_DESC: begin
            state_in = Q_DESC_CMP;
         end
         Q_DESC_CMP: begin
            if (anc_a != anc_b) begin
               a_in = anc_a;
               b_in = anc_b;
            end
            if (level_ff == '0) begin
               state_in = Q_FIN;
            end else begin
               level_in = level_ff - 1'b1;
               state_in = Q_DESC;
            end
         end
         Q_FIN: begin
            state_in = Q_FIN_WR;
         end
         Q_FIN_WR: begin
            result_in = anc_a;
            state_in  = PUT;
         end
         // hand the result to the response register
         PUT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = result_ff;
               state_in     = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         level_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      a_ff        <= a_in;
      b_ff        <= b_in;
      mid_ff      <= mid_in;
      result_ff   <= result_in;
      diff_ff     <= diff_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_common_ancestor = rsp_data_ff;

   // a response only appears when the sequencer hands one over
   a_rsp_from_put: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == PUT))
      else $error("response raised outside the hand-over state");

   // a query walk only starts from an accepted query request
   a_query_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == Q_DEP) |-> $past(req_valid && !req_stall && req_operation == OP_QUERY))
      else $error("query walk started without a query request");

   // the level counter stays inside the table while working
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != IDLE) |-> (level_ff <= LEVEL_TOP))
      else $error("lifting level out of range");

   // a load never produces a response
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (state_ff == LD_WR && level_ff == LEVEL_TOP) |=> !$rose(rsp_valid))
      else $error("load produced a response");

endmodule : lowest_common_ancestor_lifting

`default_nettype wire

// ===== sim/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import lcal_pkg::*;

   logic     clock           = 1'b0;
   logic     reset           = 1'b1;
   logic     req_valid       = 1'b0;
   logic     req_stall;
   logic     req_operation   = OP_LOAD;
   node_type req_first_node  = '0;
   node_type req_second_node = '0;
   logic     rsp_valid;
   logic     rsp_stall       = 1'b0;
   node_type rsp_common_ancestor;

   // predicted tree: depth per node and 2^k-th ancestor per node
   depth_type tree_depth [MAX_NODES];
   node_type  tree_lift [LOG_LEVELS][MAX_NODES];

   // common ancestors still owed by the block, oldest first
   node_type  ancestor_expected [$];
   node_type  ancestor_want;

   int        mismatch_count = 0;
   int        sent_count     = 0;
   int        stall_left     = 0;
   bit        no_idle        = 1'b0;

   lowest_common_ancestor_lifting i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_operation       (req_operation),
      .req_first_node      (req_first_node),
      .req_second_node     (req_second_node),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_common_ancestor (rsp_common_ancestor)
   );

   always #4 clock = ~clock;

   // idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle) return 0;
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic node_type any_node();
      return node_type'($urandom_range(1, MAX_NODES - 1));
   endfunction

   // parent link: depth from the parent, lifting entries level by level
   function automatic void record_link(node_type node, node_type parent);
      int unsigned d;
      node_type    mid;
      if (node == '0) return;
      if (parent == '0) begin
         d = 0;
      end else begin
         d = tree_depth[parent];
         d = d + 1;
         if (d > DEPTH_MAX) d = DEPTH_MAX;
      end
      tree_depth[node]   = depth_type'(d);
      tree_lift[0][node] = parent;
      for (int k = 1; k < LOG_LEVELS; k++) begin
         mid                = tree_lift[k - 1][node];
         tree_lift[k][node] = tree_lift[k - 1][mid];
      end
   endfunction

   // lift the deeper node to the same depth, then both from the top level down
   function automatic node_type common_ancestor_of(node_type a, node_type b);
      node_type  t;
      depth_type diff;
      if (tree_depth[a] < tree_depth[b]) begin
         t = a;
         a = b;
         b = t;
      end
      diff = tree_depth[a] - tree_depth[b];
      for (int k = 0; k < LOG_LEVELS; k++) begin
         if (diff[k]) a = tree_lift[k][a];
      end
      if (a == b) return a;
      for (int k = LOG_LEVELS - 1; k >= 0; k--) begin
         if (tree_lift[k][a] != tree_lift[k][b]) begin
            a = tree_lift[k][a];
            b = tree_lift[k][b];
         end
      end
      return tree_lift[0][a];
   endfunction

   // one request; starts and ends at a falling edge
   task automatic send_request(input logic op, input node_type node_a,
                               input node_type node_b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_first_node  <= node_a;
      req_second_node <= node_b;
      do @(posedge clock); while (req_stall);
      if (op == OP_QUERY) ancestor_expected.push_back(common_ancestor_of(node_a, node_b));
      else record_link(node_a, node_b);
      sent_count++;
      @(negedge clock);
   endtask

   // hold off new requests until every response is back
   task automatic wait_for_responses();
      req_valid <= 1'b0;
      @(negedge clock);
      while (ancestor_expected.size() > 0) @(negedge clock);
   endtask

   // small tree, second root, null node, ignored load, self and cyclic links
   task automatic test_small_tree();
      send_request(OP_LOAD, 1, 0);
      send_request(OP_LOAD, 2, 1);
      send_request(OP_LOAD, 3, 1);
      send_request(OP_LOAD, 4, 2);
      send_request(OP_LOAD, 1023, 4);
      send_request(OP_LOAD, 512, 1023);
      send_request(OP_LOAD, 700, 0);
      send_request(OP_LOAD, 0, 3);
      send_request(OP_QUERY, 512, 3);
      send_request(OP_QUERY, 3, 512);
      send_request(OP_QUERY, 1023, 4);
      send_request(OP_QUERY, 2, 2);
      send_request(OP_QUERY, 512, 0);
      send_request(OP_QUERY, 700, 512);
      send_request(OP_QUERY, 1023, 1023);
      send_request(OP_LOAD, 3, 3);
      send_request(OP_QUERY, 3, 4);
      send_request(OP_LOAD, 2, 512);
      send_request(OP_QUERY, 512, 3);
      send_request(OP_QUERY, 4, 1023);
      send_request(OP_LOAD, 700, 1023);
      send_request(OP_QUERY, 700, 512);
      wait_for_responses();
   endtask

   // one chain over every node, then depth saturation through relinks
   task automatic test_deep_chain();
      send_request(OP_LOAD, 1, 0);
      for (int k = 2; k < MAX_NODES; k++) begin
         no_idle = (k >= 300 && k < 600);
         send_request(OP_LOAD, node_type'(k), node_type'(k - 1));
      end
      no_idle = 1'b0;
      send_request(OP_QUERY, 1023, 1);
      send_request(OP_QUERY, 1023, 512);
      send_request(OP_QUERY, 700, 1000);
      send_request(OP_QUERY, 1023, 0);
      repeat (25) send_request(OP_QUERY, any_node(), any_node());
      send_request(OP_LOAD, 5, 1023);
      send_request(OP_LOAD, 6, 5);
      send_request(OP_LOAD, 7, 6);
      send_request(OP_QUERY, 6, 3);
      send_request(OP_QUERY, 7, 1023);
      send_request(OP_QUERY, 7, 6);
      send_request(OP_QUERY, 1000, 7);
      wait_for_responses();
   endtask

   // random trees built parents-first with queries among their nodes, plus noise
   task automatic test_random_trees(input int item_goal);
      node_type members [$];
      node_type n;
      node_type p;
      node_type a;
      node_type b;
      int       size;
      int       stop_at;
      stop_at = sent_count + item_goal;
      while (sent_count < stop_at) begin
         no_idle = ($urandom_range(0, 7) == 0);
         members.delete();
         if ($urandom_range(0, 9) < 8) begin
            size = $urandom_range(2, 30);
            for (int i = 0; i < size; i++) begin
               n = any_node();
               if (i == 0) p = ($urandom_range(0, 3) == 0) ? any_node() : node_type'(0);
               else if ($urandom_range(0, 1) == 1) p = members[members.size() - 1];
               else p = members[$urandom_range(0, members.size() - 1)];
               send_request(OP_LOAD, n, p);
               members.push_back(n);
            end
            repeat ($urandom_range(1, size)) begin
               a = members[$urandom_range(0, members.size() - 1)];
               case ($urandom_range(0, 9))
                  0: b = '0;
                  1: b = any_node();
                  default: b = members[$urandom_range(0, members.size() - 1)];
               endcase
               send_request(OP_QUERY, a, b);
            end
         end else begin
            repeat ($urandom_range(1, 8)) begin
               send_request(logic'($urandom_range(0, 1)), any_node(),
                            node_type'($urandom_range(0, MAX_NODES - 1)));
            end
         end
         if ($urandom_range(0, 15) == 0) wait_for_responses();
      end
      no_idle = 1'b0;
   endtask

   // response stall: random stretches, same length mix as the request gaps
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         stall_left = pick_gap();
         rsp_stall <= 1'b0;
      end
   end

   // compare each accepted response with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (ancestor_expected.size() == 0) begin
            $error("rsp_common_ancestor: expected none, actual %0d", rsp_common_ancestor);
            mismatch_count++;
         end else begin
            ancestor_want = ancestor_expected.pop_front();
            if (rsp_common_ancestor !== ancestor_want) begin
               $error("rsp_common_ancestor: expected %0d, actual %0d",
                      ancestor_want, rsp_common_ancestor);
               mismatch_count++;
            end
         end
      end
   end

   // run limit
   initial begin
      #10ms;
      $display("tb_top: FAIL");
      $finish;
   end

   initial begin
      foreach (tree_depth[i]) tree_depth[i] = '0;
      foreach (tree_lift[k, i]) tree_lift[k][i] = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_small_tree();
      test_deep_chain();
      test_random_trees(700);

      // drain, then let a trailing load finish
      wait_for_responses();
      repeat (60) @(posedge clock);
      if (ancestor_expected.size() > 0) begin
         $error("rsp_common_ancestor: %0d expected responses never came",
                ancestor_expected.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
